[rtl/drmp_pkg.sv]
// drmp_pkg: shared types and constants for the dense row normalise block
// used by drmp_divider and dense_row_normalize_mod_prime_top
`timescale 1ns / 1ps

package drmp_pkg;

    // digits of the shared divider: quotient bits resolved per cycle
    localparam int DIV_DIGITS = 4;
    localparam int DIV_STEP_W = 5;

    // divider pass lengths, in steps of DIV_DIGITS bits, for each dividend width
    localparam int RED_STEPS = 64 / DIV_DIGITS;
    localparam int EU_STEPS  = 16 / DIV_DIGITS;
    localparam int NRM_STEPS = 32 / DIV_DIGITS;

    // divider start request
    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_req;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RED,
        S_HEAD,
        S_EU_CHK,
        S_EU_DIV,
        S_EU_MUL,
        S_EU_UPD,
        S_NMUL,
        S_NSTART,
        S_NMOD,
        S_DONE
    } t_state;

endpackage

[rtl/drmp_divider.sv]
// drmp_divider: shared iterative restoring divider, 64-bit dividend by 16-bit divisor
// resolves DIV_DIGITS quotient bits per cycle; depends on drmp_pkg
`timescale 1ns / 1ps

module drmp_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  drmp_pkg::t_div_req i_req,
    input  logic [63:0]        i_dividend,
    input  logic [15:0]        i_divisor,
    output drmp_pkg::t_div_sts o_sts,
    output logic [15:0]        o_rem,
    output logic [15:0]        o_quo
);

    logic                            r_busy;
    logic [drmp_pkg::DIV_STEP_W-1:0] r_cnt;
    logic [63:0]                     r_dvd;
    logic [15:0]                     r_div;
    logic [15:0]                     r_rem;
    logic [15:0]                     r_quo;

    logic [63:0] n_dvd;
    logic [15:0] n_rem;
    logic [15:0] n_quo;

    // several shift-compare-subtract digits per cycle
    always_comb begin
        logic [16:0] v_rem;
        logic [63:0] v_dvd;
        logic [15:0] v_quo;
        v_rem = {1'b0, r_rem};
        v_dvd = r_dvd;
        v_quo = r_quo;
        for (int k = 0; k < drmp_pkg::DIV_DIGITS; k++) begin
            v_rem = {v_rem[15:0], v_dvd[63]};
            v_dvd = {v_dvd[62:0], 1'b0};
            if (v_rem >= {1'b0, r_div}) begin
                v_rem = v_rem - {1'b0, r_div};
                v_quo = {v_quo[14:0], 1'b1};
            end else begin
                v_quo = {v_quo[14:0], 1'b0};
            end
        end
        n_rem = v_rem[15:0];
        n_dvd = v_dvd;
        n_quo = v_quo;
    end

    // step counter and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && (r_cnt == '0);
    assign o_rem      = r_rem;
    assign o_quo      = r_quo;

endmodule

[rtl/drmp_mult.sv]
// drmp_mult: shared registered 18x18 signed multiplier
// no package dependencies
`timescale 1ns / 1ps

module drmp_mult (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [17:0] i_a,
    input  logic signed [17:0] i_b,
    output logic signed [35:0] o_prod
);

    logic signed [35:0] r_prod;

    // one multiply per enabled cycle, registered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

[rtl/dense_row_normalize_mod_prime_top.sv]
// Dense row normaliser modulo a prime: reduces 64-bit accumulators and scales each
// row by the inverse of its first nonzero element. Depends on drmp_pkg, drmp_divider, drmp_mult
`timescale 1ns / 1ps

// Usage
// Slave stream: s_tdata carries one 64-bit accumulator, s_tlast marks the last
// element of a row. Master stream: one result per element; m_tlast repeats the
// row end, m_tuser is the head-found flag.
// Configuration: i_cfg_we writes the 16-bit modulus (reset value 65521); write
// it only while no element is in flight.
// Sequence: an element before the head, or in a row with no head, goes through
// the divider to reduce the 64-bit value, one head check and a load of the output
// register. Later elements add one multiply and a divider pass for the product
// reduction, plus sequencing. The head element also runs the extended Euclidean
// inverse, round by round (start, divide, multiply, update), at most about 24
// rounds for a 16-bit modulus, plus one closing check.
// Only one element is worked at a time and s_tready is low while it is in flight.
// A finished result sits in the output register; the next request is taken
// while it waits, and the sequencer holds before writing the following result.
// Reset is synchronous: the row state clears and the modulus returns to 65521.
// Rows end on s_tlast or after ROW_LEN elements.
module dense_row_normalize_mod_prime_top #(
    parameter int ROW_LEN = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] value
    input  logic        i_s_tlast,
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [15:0] normalized, [27:16] position, [39:28] head_position
    output logic        o_m_tuser,   // [0] head_found
    output logic        o_m_tlast
);

    localparam int RC_W = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;

    drmp_pkg::t_state r_state;
    drmp_pkg::t_state n_state;

    logic [15:0]       r_modulus;
    logic [15:0]       r_p;
    logic              r_last;
    logic [15:0]       r_res;
    logic [15:0]       r_inv;
    logic              r_found;
    logic [11:0]       r_head_pos;
    logic [11:0]       r_elem_cnt;
    logic [RC_W-1:0]   r_row_cnt;
    logic [15:0]       r_old_r;
    logic [15:0]       r_cur_r;
    logic signed [17:0] r_old_s;
    logic signed [17:0] r_cur_s;
    logic [15:0]       r_norm;

    logic              r_out_valid;
    logic [15:0]       r_out_norm;
    logic [11:0]       r_out_pos;
    logic              r_out_found;
    logic [11:0]       r_out_hpos;
    logic              r_out_end;

    drmp_pkg::t_div_req w_div_req;
    drmp_pkg::t_div_sts w_div_sts;
    logic [63:0]        w_dividend;
    logic [15:0]        w_divisor;
    logic [15:0]        w_rem;
    logic [15:0]        w_quo;

    logic               w_mul_en;
    logic signed [17:0] w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [35:0] w_prod;

    logic               w_accept;
    logic               w_p_ge2;
    logic               w_new_head;
    logic signed [35:0] w_new_s;
    logic [18:0]        w_s_adj;
    logic [15:0]        w_inv_fin;
    logic               w_end;
    logic               w_out_load;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_p_ge2    = (r_p > 16'd1);
    assign w_new_head = !r_found && (r_res != 16'd0);
    assign w_end      = r_last || (r_row_cnt == RC_W'(ROW_LEN - 1));
    assign w_out_load = (r_state == drmp_pkg::S_DONE) && (!r_out_valid || i_m_tready);

    // euclid coefficient update and final inverse fix-up
    assign w_new_s   = 36'(r_old_s) - w_prod;
    assign w_s_adj   = 19'(r_old_s) + {3'b000, r_p};
    assign w_inv_fin = (r_old_r != 16'd1) ? 16'd0 :
                       (r_old_s < 0)      ? w_s_adj[15:0] : r_old_s[15:0];

    // shared units
    drmp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_sts      (w_div_sts),
        .o_rem      (w_rem),
        .o_quo      (w_quo)
    );

    drmp_mult u_mult (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            drmp_pkg::S_IDLE: begin
                if (w_accept) n_state = drmp_pkg::S_RED;
            end
            drmp_pkg::S_RED: begin
                if (w_div_sts.done) n_state = drmp_pkg::S_HEAD;
            end
            drmp_pkg::S_HEAD: begin
                if (w_new_head) begin
                    n_state = drmp_pkg::S_EU_CHK;
                end else if (r_found && w_p_ge2) begin
                    n_state = drmp_pkg::S_NMUL;
                end else begin
                    n_state = drmp_pkg::S_DONE;
                end
            end
            drmp_pkg::S_EU_CHK: begin
                if (r_cur_r == 16'd0) begin
                    n_state = drmp_pkg::S_NMUL;
                end else begin
                    n_state = drmp_pkg::S_EU_DIV;
                end
            end
            drmp_pkg::S_EU_DIV: begin
                if (w_div_sts.done) n_state = drmp_pkg::S_EU_MUL;
            end
            drmp_pkg::S_EU_MUL: n_state = drmp_pkg::S_EU_UPD;
            drmp_pkg::S_EU_UPD: n_state = drmp_pkg::S_EU_CHK;
            drmp_pkg::S_NMUL:   n_state = drmp_pkg::S_NSTART;
            drmp_pkg::S_NSTART: n_state = drmp_pkg::S_NMOD;
            drmp_pkg::S_NMOD: begin
                if (w_div_sts.done) n_state = drmp_pkg::S_DONE;
            end
            drmp_pkg::S_DONE: begin
                if (w_out_load) n_state = drmp_pkg::S_IDLE;
            end
            default: n_state = drmp_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: unit requests and operand selection
    always_comb begin
        w_div_req.start = 1'b0;
        w_div_req.steps = '0;
        w_dividend      = '0;
        w_divisor       = r_p;
        w_mul_en        = 1'b0;
        w_mul_a         = 18'({2'b00, r_res});
        w_mul_b         = 18'({2'b00, r_inv});
        o_s_tready      = 1'b0;
        case (r_state)
            drmp_pkg::S_IDLE: begin
                // ready only once out of reset
                o_s_tready      = i_rst_n;
                w_div_req.start = w_accept;
                w_div_req.steps = drmp_pkg::DIV_STEP_W'(drmp_pkg::RED_STEPS);
                w_dividend      = i_s_tdata;
                w_divisor       = r_modulus;
            end
            drmp_pkg::S_EU_CHK: begin
                w_div_req.start = (r_cur_r != 16'd0);
                w_div_req.steps = drmp_pkg::DIV_STEP_W'(drmp_pkg::EU_STEPS);
                w_dividend      = {r_old_r, 48'd0};
                w_divisor       = r_cur_r;
            end
            drmp_pkg::S_EU_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = 18'({2'b00, w_quo});
                w_mul_b  = r_cur_s;
            end
            drmp_pkg::S_NMUL: begin
                w_mul_en = 1'b1;
            end
            drmp_pkg::S_NSTART: begin
                w_div_req.start = 1'b1;
                w_div_req.steps = drmp_pkg::DIV_STEP_W'(drmp_pkg::NRM_STEPS);
                w_dividend      = {w_prod[31:0], 32'd0};
            end
            default: begin
            end
        endcase
    end

    // state register and modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= drmp_pkg::S_IDLE;
            r_modulus <= 16'd65521;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_modulus <= i_cfg_wdata;
        end
    end

    // per-element working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p    <= r_modulus;
            r_last <= i_s_tlast;
        end
        if (r_state == drmp_pkg::S_RED && w_div_sts.done) begin
            r_res <= w_p_ge2 ? w_rem : 16'd0;
        end
        if (r_state == drmp_pkg::S_HEAD) begin
            r_norm  <= 16'd0;
            r_old_r <= r_res;
            r_cur_r <= r_p;
            r_old_s <= 18'sd1;
            r_cur_s <= 18'sd0;
        end
        if (r_state == drmp_pkg::S_EU_UPD) begin
            r_old_r <= r_cur_r;
            r_cur_r <= w_rem;
            r_old_s <= r_cur_s;
            r_cur_s <= w_new_s[17:0];
        end
        if (r_state == drmp_pkg::S_NMOD && w_div_sts.done) begin
            r_norm <= w_rem;
        end
    end

    // row state: head, inverse and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= 1'b0;
            r_inv      <= '0;
            r_head_pos <= '0;
            r_elem_cnt <= '0;
            r_row_cnt  <= '0;
        end else if (w_out_load) begin
            if (w_end) begin
                r_found    <= 1'b0;
                r_inv      <= '0;
                r_head_pos <= '0;
                r_elem_cnt <= '0;
                r_row_cnt  <= '0;
            end else begin
                r_elem_cnt <= r_elem_cnt + 1'b1;
                r_row_cnt  <= r_row_cnt + 1'b1;
            end
        end else if (r_state == drmp_pkg::S_HEAD && w_new_head) begin
            r_found    <= 1'b1;
            r_head_pos <= r_elem_cnt;
        end else if (r_state == drmp_pkg::S_EU_CHK && r_cur_r == 16'd0) begin
            r_inv <= w_inv_fin;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_norm  <= r_norm;
            r_out_pos   <= r_elem_cnt;
            r_out_found <= r_found;
            r_out_hpos  <= r_found ? r_head_pos : 12'd0;
            r_out_end   <= w_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_hpos, r_out_pos, r_out_norm};
    assign o_m_tuser  = r_out_found;
    assign o_m_tlast  = r_out_end;

`ifndef SYNTHESIS
    // the divider is never restarted in the middle of a pass
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_sts.busy)
        else $error("divider started while busy");

    // an accepted request closes the slave side on the next cycle
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("slave side still ready after a request");

    // a result without a head reports head position zero
    a_no_head_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[39:28] == 12'd0))
        else $error("head position set without a head");

    // each euclid remainder is below the divisor it came from
    a_eu_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drmp_pkg::S_EU_UPD) |-> (w_rem < r_cur_r))
        else $error("euclid remainder not reduced");
`endif

endmodule

[tb/dense_row_normalize_mod_prime_top_tb.sv]
// Self-checking testbench for dense_row_normalize_mod_prime_top: streams rows of
// 64-bit accumulators under random idling and checks every result in order.
// Depends on the RTL top level only (drmp_pkg is pulled in by the block itself).
`timescale 1ns / 1ps

module dense_row_normalize_mod_prime_top_tb;

    localparam int ROW_LIMIT      = 4096;
    localparam int STALL_LIMIT    = 20000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 1700;

    // one expected result
    typedef struct {
        logic [15:0] normalized;
        logic [11:0] position;
        logic        head_found;
        logic [11:0] head_position;
        logic        row_end;
    } t_row_result;

    // row state tracker and expected result store
    class row_norm_scoreboard;
        logic [15:0] modulus;
        bit          found;
        logic [15:0] inverse;
        logic [11:0] counter;
        logic [11:0] head_pos;
        int unsigned row_count;
        int unsigned failures;
        t_row_result awaiting[$];

        function new();
            modulus   = 16'd65521;
            found     = 1'b0;
            inverse   = '0;
            counter   = '0;
            head_pos  = '0;
            row_count = 0;
            failures  = 0;
        endfunction

        // extended euclid; zero when the residue shares a factor with p
        function automatic logic [15:0] inverse_of(longint r, longint p);
            longint a, b, s_old, s_cur, q, t;
            a = r;
            b = p;
            s_old = 1;
            s_cur = 0;
            while (b != 0) begin
                q = a / b;
                t = a - q * b;
                a = b;
                b = t;
                t = s_old - q * s_cur;
                s_old = s_cur;
                s_cur = t;
            end
            if (a != 1) return '0;
            s_old = s_old % p;
            if (s_old < 0) s_old += p;
            return s_old[15:0];
        endfunction

        function int unsigned pending();
            return awaiting.size();
        endfunction

        // work out the result of an accepted request
        function void note_request(logic [63:0] value, logic last);
            t_row_result res;
            logic [63:0] residue;
            logic [63:0] product;
            residue = (modulus < 16'd2) ? 64'd0 : value % {48'd0, modulus};
            if (!found && residue != 0) begin
                found    = 1'b1;
                head_pos = counter;
                inverse  = inverse_of(longint'(residue), longint'(modulus));
            end
            product = residue * {48'd0, inverse};
            res.normalized    = (found && modulus >= 16'd2) ?
                                16'(product % {48'd0, modulus}) : 16'd0;
            res.position      = counter;
            res.head_found    = found;
            res.head_position = found ? head_pos : 12'd0;
            res.row_end       = last || (row_count + 1 >= ROW_LIMIT);
            awaiting = {awaiting, res};
            if (res.row_end) begin
                found     = 1'b0;
                inverse   = '0;
                counter   = '0;
                head_pos  = '0;
                row_count = 0;
            end else begin
                counter   = counter + 12'd1;
                row_count = row_count + 1;
            end
        endfunction

        // compare an accepted result with the oldest expectation
        function void check_result(logic [39:0] tdata, logic tuser, logic tlast);
            t_row_result exp_res;
            if (awaiting.size() == 0) begin
                $error("result with no request outstanding: tdata=%h", tdata);
                failures++;
                return;
            end
            exp_res = awaiting.pop_front();
            if (tdata[15:0] !== exp_res.normalized) begin
                $error("normalized: expected %0d, actual %0d",
                       exp_res.normalized, tdata[15:0]);
                failures++;
            end
            if (tdata[27:16] !== exp_res.position) begin
                $error("position: expected %0d, actual %0d",
                       exp_res.position, tdata[27:16]);
                failures++;
            end
            if (tuser !== exp_res.head_found) begin
                $error("head_found: expected %0d, actual %0d", exp_res.head_found, tuser);
                failures++;
            end
            if (tdata[39:28] !== exp_res.head_position) begin
                $error("head_position: expected %0d, actual %0d",
                       exp_res.head_position, tdata[39:28]);
                failures++;
            end
            if (tlast !== exp_res.row_end) begin
                $error("row_end: expected %0d, actual %0d", exp_res.row_end, tlast);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    row_norm_scoreboard norm_board;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned rx_hold_left;
    int unsigned quiet_cycles;

    dense_row_normalize_mod_prime_top #(
        .ROW_LEN(ROW_LIMIT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stall bursts, plus a long hold when asked
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 19) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            norm_board.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one request and wait for it to be taken
    task automatic send_elem(input logic [63:0] value, input logic last);
        int unsigned gap;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 19);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  <= value;
        i_s_tlast  <= last;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        norm_board.note_request(value, last);
        @(negedge i_clk);
    endtask

    // stop offering and let every outstanding result drain
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (norm_board.pending() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_modulus(input logic [15:0] p);
        wait_idle();
        i_cfg_wdata <= p;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        norm_board.modulus = p;
    endtask

    // value whose residue is zero under the current modulus
    function automatic logic [63:0] zero_residue_value();
        logic [63:0] v;
        logic [15:0] p;
        p = norm_board.modulus;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) return 64'd0;
        if (p < 16'd2) return v;
        return v - (v % {48'd0, p});
    endfunction

    // any value, weighted towards interesting residues
    function automatic logic [63:0] any_value();
        logic [15:0] p;
        p = norm_board.modulus;
        case ($urandom_range(0, 9))
            0: return zero_residue_value();
            1: return '1;
            2: return 64'd1;
            3, 4: return (p == 0) ? 64'd0 : 64'($urandom_range(0, p - 1));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // a row: some zero-residue elements, then random content
    task automatic send_row(input int unsigned len, input int unsigned lead,
                            input bit close);
        for (int unsigned i = 0; i < len; i++)
            send_elem((i < lead) ? zero_residue_value() : any_value(),
                      close && (i == len - 1));
    endtask

    // main sequence
    initial begin
        logic [15:0] primes[14];
        logic [15:0] others[9];
        logic [15:0] p;
        int unsigned sent;
        int unsigned len;
        int unsigned phase;

        primes = '{16'd2, 16'd3, 16'd5, 16'd7, 16'd13, 16'd31, 16'd251, 16'd257,
                   16'd509, 16'd4093, 16'd8191, 16'd32749, 16'd65519, 16'd65521};
        others = '{16'd0, 16'd1, 16'd4, 16'd12, 16'd100, 16'd255, 16'd1024,
                   16'd65535, 16'd0};

        norm_board   = new();
        tx_idle_pct  = 10;
        rx_idle_pct  = 5;
        rx_hold_left = 0;
        quiet_cycles = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tlast   <= 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset modulus: leading zeros, head of all ones, zero after head
        send_elem(64'd0, 1'b0);
        send_elem(64'd65521 * 64'd123456789, 1'b0);
        send_elem('1, 1'b0);
        send_elem(64'd0, 1'b0);
        send_elem(64'h8000_0000_0000_0000, 1'b1);
        send_elem(64'd1, 1'b1);

        // modulus zero and one: no head can ever be found
        write_modulus(16'd0);
        send_elem('1, 1'b0);
        send_elem(64'd12345, 1'b1);
        write_modulus(16'd1);
        send_elem({$urandom, $urandom}, 1'b0);
        send_elem(64'd7, 1'b1);

        // smallest prime
        write_modulus(16'd2);
        send_elem(64'd3, 1'b0);
        send_elem(64'd5, 1'b1);

        // composite modulus: head sharing a factor gives a zero inverse
        write_modulus(16'd65535);
        send_elem(64'd3, 1'b0);
        send_elem(64'd7, 1'b0);
        send_elem(64'd65536, 1'b1);

        // modulus changed mid-row keeps the old inverse
        write_modulus(16'd7);
        send_elem(64'd3, 1'b0);
        send_elem(64'd10, 1'b0);
        write_modulus(16'd13);
        send_elem(64'd20, 1'b0);
        send_elem(64'd26, 1'b1);

        // random rows over a series of moduli
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                p = others[$urandom_range(0, 8)];
            else
                p = primes[$urandom_range(0, 13)];
            if (phase == 5) p = 16'($urandom);
            write_modulus(p);
            tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
            // fill the block behind a long receiver hold
            if (phase == 2) rx_hold_left = LONG_HOLD;
            // last stretch runs with no idling at all
            if (sent + 200 >= RANDOM_ITEMS) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int unsigned r = 0; r < 8 && sent < RANDOM_ITEMS; r++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                   : $urandom_range(1, 24);
                if ($urandom_range(0, 9) == 0) begin
                    // noise: random values and random row markers
                    for (int unsigned i = 0; i < len; i++)
                        send_elem({$urandom, $urandom}, 1'($urandom_range(0, 3) == 0));
                end else begin
                    // leave the last row of some phases open across the write
                    send_row(len, $urandom_range(0, len),
                             !(r == 7 && $urandom_range(0, 3) == 0));
                end
                sent += len;
            end
            if (sent + 200 >= RANDOM_ITEMS && phase > 0) wait_idle();
            phase++;
        end

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (norm_board.failures == 0 && norm_board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[dense_row_normalize_mod_prime_top.f]
rtl/drmp_pkg.sv
rtl/drmp_divider.sv
rtl/drmp_mult.sv
rtl/dense_row_normalize_mod_prime_top.sv
tb/dense_row_normalize_mod_prime_top_tb.sv
